### rtl/clsf_pkg.sv
package clsf_pkg;

    localparam int POS_W = 16;
    localparam int THR_W = 22;
    localparam int MIN_W = 11;

    localparam logic [POS_W-1:0] FULL_OPEN = 16'h8000;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [THR_W-1:0] SLOPE_THR_RST  = 22'd42598;
    localparam logic [THR_W-1:0] CHANGE_THR_RST = 22'd6554;
    localparam logic [MIN_W-1:0] MIN_CLOSE_RST  = 11'd10;

    typedef enum logic [1:0] {
        REG_SLOPE_THR   = 2'd0,
        REG_CHANGE_THR  = 2'd1,
        REG_MIN_CLOSING = 2'd2
    } t_reg_idx;

    // Strobes from the sequencer to the datapath, one step of an item each.
    typedef struct packed {
        logic load_in;
        logic cap_head;
        logic rd_newest;
        logic cap_start;
        logic cap_diff;
        logic mul1;
        logic mul2;
        logic decide;
        logic load_out;
    } t_cmd;

endpackage

### rtl/clsf_regs.sv
module clsf_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [clsf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [clsf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [clsf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [clsf_pkg::THR_W-1:0]          o_slope_thr,
    output logic [clsf_pkg::THR_W-1:0]          o_change_thr,
    output logic [clsf_pkg::MIN_W-1:0]          o_min_closing
);

    logic [clsf_pkg::THR_W-1:0] r_slope_thr;
    logic [clsf_pkg::THR_W-1:0] r_change_thr;
    logic [clsf_pkg::MIN_W-1:0] r_min_closing;
    clsf_pkg::t_reg_idx         reg_idx;
    logic                       wr_en;

    assign reg_idx = clsf_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope_thr   <= clsf_pkg::SLOPE_THR_RST;
            r_change_thr  <= clsf_pkg::CHANGE_THR_RST;
            r_min_closing <= clsf_pkg::MIN_CLOSE_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                clsf_pkg::REG_SLOPE_THR:   r_slope_thr   <= pwdata[clsf_pkg::THR_W-1:0];
                clsf_pkg::REG_CHANGE_THR:  r_change_thr  <= pwdata[clsf_pkg::THR_W-1:0];
                clsf_pkg::REG_MIN_CLOSING: r_min_closing <= pwdata[clsf_pkg::MIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            clsf_pkg::REG_SLOPE_THR:   prdata = clsf_pkg::APB_DATA_W'(r_slope_thr);
            clsf_pkg::REG_CHANGE_THR:  prdata = clsf_pkg::APB_DATA_W'(r_change_thr);
            clsf_pkg::REG_MIN_CLOSING: prdata = clsf_pkg::APB_DATA_W'(r_min_closing);
            default:                   prdata = '0;
        endcase
    end

    assign o_slope_thr   = r_slope_thr;
    assign o_change_thr  = r_change_thr;
    assign o_min_closing = r_min_closing;

endmodule

### rtl/clsf_ctrl.sv
module clsf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output clsf_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_RD_START,
        ST_RD_NEWEST,
        ST_DIFF,
        ST_MUL1,
        ST_MUL2,
        ST_DECIDE,
        ST_OUT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   in_fire;
    logic   out_load;

    assign in_fire  = (r_state == ST_IDLE) && r_in_ready && i_in_valid;
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_state    <= ST_HEAD;
                        r_in_ready <= 1'b0;
                    end
                end
                ST_HEAD:      r_state <= ST_RD_START;
                ST_RD_START:  r_state <= ST_RD_NEWEST;
                ST_RD_NEWEST: r_state <= ST_DIFF;
                ST_DIFF:      r_state <= ST_MUL1;
                ST_MUL1:      r_state <= ST_MUL2;
                ST_MUL2:      r_state <= ST_DECIDE;
                ST_DECIDE:    r_state <= ST_OUT;
                ST_OUT: begin
                    if (out_load) begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= ST_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_in   = in_fire;
        o_cmd.cap_head  = (r_state == ST_HEAD);
        o_cmd.rd_newest = (r_state == ST_RD_NEWEST);
        o_cmd.cap_start = (r_state == ST_RD_NEWEST);
        o_cmd.cap_diff  = (r_state == ST_DIFF);
        o_cmd.mul1      = (r_state == ST_MUL1);
        o_cmd.mul2      = (r_state == ST_MUL2);
        o_cmd.decide    = (r_state == ST_DECIDE);
        o_cmd.load_out  = out_load;
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

### rtl/clsf_dp.sv
module clsf_dp #(
    parameter int WINDOW_LEN = 100
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  clsf_pkg::t_cmd                i_cmd,
    input  logic [clsf_pkg::POS_W-1:0]    i_position,
    input  logic                          i_closing,
    input  logic [clsf_pkg::THR_W-1:0]    i_slope_thr,
    input  logic [clsf_pkg::THR_W-1:0]    i_change_thr,
    input  logic [clsf_pkg::MIN_W-1:0]    i_min_closing,
    output logic                          o_steep_fault,
    output logic                          o_jam_fault
);

    localparam int PW = clsf_pkg::POS_W;
    localparam int AW = $clog2(WINDOW_LEN);
    localparam int EW = $clog2(WINDOW_LEN + 1);
    localparam int GW = PW + EW;
    localparam int CW = ((GW > clsf_pkg::THR_W) ? GW : clsf_pkg::THR_W) + EW;
    localparam int MW = (EW > clsf_pkg::MIN_W) ? EW : clsf_pkg::MIN_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_LEN - 1);
    localparam logic [EW-1:0] LEN_E     = EW'(WINDOW_LEN);
    localparam logic [AW:0]   LEN_A     = (AW + 1)'(WINDOW_LEN);

    // Position window, addressed by slot; slots beyond the fill count read as fully open.
    logic [PW-1:0] r_pos_mem  [WINDOW_LEN];
    // Slots of the samples that are not fully open, oldest first.
    logic [AW-1:0] r_fifo_mem [WINDOW_LEN];

    logic [AW-1:0] r_oldest;
    logic [AW-1:0] r_fhead;
    logic [AW-1:0] r_ftail;
    logic [EW-1:0] r_fcount;
    logic [EW-1:0] r_fill;

    logic [PW-1:0] r_mem_q;
    logic          r_q_valid;
    logic [AW-1:0] r_fifo_q;

    logic [PW-1:0] r_pos_in;
    logic          r_closing;
    logic [AW-1:0] r_head_slot;
    logic [AW-1:0] r_start_slot;
    logic [EW-1:0] r_elapsed;
    logic [PW-1:0] r_start_val;
    logic [PW-1:0] r_d_start;
    logic [PW-1:0] r_d_new;
    logic [GW-1:0] r_g_num;
    logic [GW-1:0] r_l_val;
    logic [CW-1:0] r_thr_el;
    logic [CW-1:0] r_chg_el;
    logic [CW-1:0] r_rhs;
    logic          r_steep_pre;
    logic          r_steep;
    logic          r_jam;
    logic          r_out_steep;
    logic          r_out_jam;

    logic          fifo_empty;
    logic [AW:0]   lead_wrap;
    logic [AW-1:0] lead;
    logic [AW-1:0] start_age;
    logic [AW-1:0] newest_slot;
    logic [AW-1:0] rd_addr;
    logic          rd_valid;
    logic [PW-1:0] rd_val;
    logic          pop;
    logic          push;
    logic [CW-1:0] g_ext;
    logic [CW-1:0] diff;

    assign fifo_empty  = (r_fcount == '0);
    assign lead_wrap   = {1'b0, r_fifo_q} + LEN_A - {1'b0, r_oldest};
    assign lead        = (r_fifo_q >= r_oldest) ? (r_fifo_q - r_oldest) : lead_wrap[AW-1:0];
    assign start_age   = fifo_empty ? LAST_SLOT : lead;
    assign newest_slot = (r_oldest == '0) ? LAST_SLOT : (r_oldest - 1'b1);
    assign rd_addr     = i_cmd.rd_newest ? newest_slot : r_start_slot;
    assign rd_valid    = (r_fill == LEN_E) || (EW'(rd_addr) < r_fill);
    assign rd_val      = r_q_valid ? r_mem_q : clsf_pkg::FULL_OPEN;

    // The dropped sample is the head of the queue exactly when its leading run is empty.
    assign pop  = !fifo_empty && (r_head_slot == r_oldest);
    assign push = (r_pos_in != clsf_pkg::FULL_OPEN);

    assign g_ext = CW'(r_g_num);
    assign diff  = (g_ext > r_rhs) ? (g_ext - r_rhs) : (r_rhs - g_ext);

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_pos_mem[r_oldest] <= r_pos_in;
        end
        r_mem_q   <= r_pos_mem[rd_addr];
        r_q_valid <= rd_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && push) begin
            r_fifo_mem[r_ftail] <= r_oldest;
        end
        r_fifo_q <= r_fifo_mem[r_fhead];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_fhead  <= '0;
            r_ftail  <= '0;
            r_fcount <= '0;
            r_fill   <= '0;
        end else if (i_cmd.decide) begin
            r_oldest <= (r_oldest == LAST_SLOT) ? '0 : (r_oldest + 1'b1);
            if (r_fill != LEN_E) begin
                r_fill <= r_fill + 1'b1;
            end
            if (pop) begin
                r_fhead <= (r_fhead == LAST_SLOT) ? '0 : (r_fhead + 1'b1);
            end
            if (push) begin
                r_ftail <= (r_ftail == LAST_SLOT) ? '0 : (r_ftail + 1'b1);
            end
            r_fcount <= r_fcount + EW'(push) - EW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pos_in  <= i_position;
            r_closing <= i_closing;
        end
        if (i_cmd.cap_head) begin
            r_head_slot  <= r_fifo_q;
            r_start_slot <= fifo_empty ? newest_slot : r_fifo_q;
            r_elapsed    <= LEN_E - EW'(start_age);
        end
        if (i_cmd.cap_start) begin
            r_start_val <= rd_val;
        end
        if (i_cmd.cap_diff) begin
            r_d_start <= (r_start_val > r_pos_in) ? (r_start_val - r_pos_in)
                                                  : (r_pos_in - r_start_val);
            r_d_new   <= (rd_val > r_pos_in) ? (rd_val - r_pos_in) : (r_pos_in - rd_val);
        end
        if (i_cmd.mul1) begin
            r_g_num  <= GW'(r_d_start) * GW'(LEN_E);
            r_l_val  <= GW'(r_d_new) * GW'(LEN_E);
            r_thr_el <= CW'(i_slope_thr) * CW'(r_elapsed);
            r_chg_el <= CW'(i_change_thr) * CW'(r_elapsed);
        end
        if (i_cmd.mul2) begin
            r_rhs       <= CW'(r_l_val) * CW'(r_elapsed);
            r_steep_pre <= (g_ext > r_thr_el) && (CW'(r_l_val) > CW'(i_slope_thr))
                           && (MW'(r_elapsed) > MW'(i_min_closing));
        end
        if (i_cmd.decide) begin
            r_steep <= r_closing && r_steep_pre;
            r_jam   <= r_closing && (diff > r_chg_el);
        end
        if (i_cmd.load_out) begin
            r_out_steep <= r_steep;
            r_out_jam   <= r_jam;
        end
    end

    assign o_steep_fault = r_out_steep;
    assign o_jam_fault   = r_out_jam;

endmodule

### rtl/closing_slope_fault_detector.sv
// Closing slope fault detector. Each input beat carries one actuator position (unsigned Q15,
// 32768 is fully open) and a closing flag, and yields one output beat with a steep-curve flag
// and a jam-or-jump flag; both flags are zero when closing is low. The last WINDOW_LEN
// positions are kept in an on-chip window that starts out fully open; a fill count stands in
// for clearing it, so the block is ready straight after reset. Slope tests are exact: the
// global slope is cross-multiplied by the elapsed sample count instead of being divided.
// An item steps through the sequencer states in order from its input beat to its output register,
// and the next input beat is taken only once the result has moved into that register, so one item
// is in flight at a time and the block waits while the output side does not keep up. The
// sequencer walks one window read port and the multiply stages in turn. Thresholds are written
// over the APB port (slope threshold at 0x0, change threshold at 0x4, minimum closing
// samples at 0x8) and should only be changed while no item is in flight.
module closing_slope_fault_detector #(
    parameter int WINDOW_LEN = 100
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [clsf_pkg::POS_W-1:0]          i_position,
    input  logic                                i_closing,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_steep_fault,
    output logic                                o_jam_fault,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [clsf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [clsf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [clsf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    clsf_pkg::t_cmd             cmd;
    logic [clsf_pkg::THR_W-1:0] slope_thr;
    logic [clsf_pkg::THR_W-1:0] change_thr;
    logic [clsf_pkg::MIN_W-1:0] min_closing;

    clsf_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_slope_thr   (slope_thr),
        .o_change_thr  (change_thr),
        .o_min_closing (min_closing)
    );

    clsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (cmd)
    );

    clsf_dp #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_position    (i_position),
        .i_closing     (i_closing),
        .i_slope_thr   (slope_thr),
        .i_change_thr  (change_thr),
        .i_min_closing (min_closing),
        .o_steep_fault (o_steep_fault),
        .o_jam_fault   (o_jam_fault)
    );

endmodule

### rtl/clsf_checker.sv
module clsf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_steep_fault,
    input logic o_jam_fault,
    input logic pready
);

    // A stalled output beat keeps its flags.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_steep_fault) && $stable(o_jam_fault))
        else $error("output beat changed while stalled");

    // Reset leaves the block ready for input with nothing to deliver.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready && !o_valid)
        else $error("block not idle after reset");

    // Only one item is in flight: input is closed for the following cycles.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready ##1 !o_ready)
        else $error("input taken while an item is in flight");

    // A result does not appear while its item is still in the early sequencer states.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !o_valid |=> !o_valid ##1 !o_valid)
        else $error("result appeared too early");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port stalled");

endmodule

bind closing_slope_fault_detector clsf_checker u_clsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_steep_fault (o_steep_fault),
    .o_jam_fault   (o_jam_fault),
    .pready        (pready)
);

### tb/closing_slope_fault_detector_tb.sv
`timescale 1ns / 1ps

module closing_slope_fault_detector_tb;

    localparam int WINDOW_LEN    = 100;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 270;
    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 40;
    localparam int STUCK_LIMIT   = 4000;

    localparam logic [clsf_pkg::APB_ADDR_W-1:0] ADDR_SPARE = 4'hC;

    typedef struct {
        logic [clsf_pkg::POS_W-1:0] position;
        logic                       closing;
    } t_sample;

    typedef struct {
        logic steep;
        logic jam;
    } t_fault;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_valid    = 1'b0;
    logic [clsf_pkg::POS_W-1:0]      i_position = '0;
    logic                            i_closing  = 1'b0;
    logic                            i_ready    = 1'b0;
    logic                            psel       = 1'b0;
    logic                            penable    = 1'b0;
    logic                            pwrite     = 1'b0;
    logic [clsf_pkg::APB_ADDR_W-1:0] paddr      = '0;
    logic [clsf_pkg::APB_DATA_W-1:0] pwdata     = '0;
    logic                            o_ready;
    logic                            o_valid;
    logic                            o_steep_fault;
    logic                            o_jam_fault;
    logic [clsf_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    closing_slope_fault_detector #(
        .WINDOW_LEN(WINDOW_LEN)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_position   (i_position),
        .i_closing    (i_closing),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_steep_fault(o_steep_fault),
        .o_jam_fault  (o_jam_fault),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 i_clk = ~i_clk;

    t_sample samples_to_send[$];
    t_fault  pending_faults[$];
    int      errors = 0;

    // Shadow of the block: position history and thresholds.
    logic [clsf_pkg::POS_W-1:0] hist_pos [WINDOW_LEN];
    int unsigned                hist_oldest;
    int unsigned                hist_lead_open;
    logic [clsf_pkg::THR_W-1:0] slope_thr_m;
    logic [clsf_pkg::THR_W-1:0] change_thr_m;
    logic [clsf_pkg::MIN_W-1:0] min_close_m;

    function automatic void clear_history();
        for (int i = 0; i < WINDOW_LEN; i++) hist_pos[i] = clsf_pkg::FULL_OPEN;
        hist_oldest    = 0;
        hist_lead_open = WINDOW_LEN;
        slope_thr_m    = clsf_pkg::SLOPE_THR_RST;
        change_thr_m   = clsf_pkg::CHANGE_THR_RST;
        min_close_m    = clsf_pkg::MIN_CLOSE_RST;
    endfunction

    function automatic longint unsigned abs_gap(longint unsigned a, longint unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Decides the two fault flags for one sample, then shifts it into the history.
    function automatic t_fault judge_sample(t_sample s);
        t_fault          f;
        int unsigned     start_age;
        longint unsigned elapsed, start_v, newest_v, g_num, l_val, lhs_rhs;
        int unsigned     n;
        start_age = (hist_lead_open < WINDOW_LEN) ? hist_lead_open : WINDOW_LEN - 1;
        elapsed   = WINDOW_LEN - start_age;
        start_v   = hist_pos[(hist_oldest + start_age) % WINDOW_LEN];
        newest_v  = hist_pos[(hist_oldest + WINDOW_LEN - 1) % WINDOW_LEN];
        g_num     = abs_gap(start_v, s.position) * WINDOW_LEN;
        l_val     = abs_gap(newest_v, s.position) * WINDOW_LEN;
        f.steep   = 1'b0;
        f.jam     = 1'b0;
        if (s.closing) begin
            f.steep = (g_num > slope_thr_m * elapsed) && (l_val > slope_thr_m)
                      && (elapsed > min_close_m);
            lhs_rhs = abs_gap(g_num, l_val * elapsed);
            f.jam   = lhs_rhs > change_thr_m * elapsed;
        end
        hist_pos[hist_oldest] = s.position;
        hist_oldest = (hist_oldest + 1) % WINDOW_LEN;
        n = 0;
        while (n < WINDOW_LEN
               && hist_pos[(hist_oldest + n) % WINDOW_LEN] == clsf_pkg::FULL_OPEN) n++;
        hist_lead_open = n;
        return f;
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 16);
        return $urandom_range(40, 150);
    endfunction

    int unsigned tx_gap  = 0;
    int unsigned tx_calm = 0;

    always @(posedge i_clk) begin : sample_driver
        t_sample s;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (tx_gap != 0) begin
                tx_gap  <= tx_gap - 1;
                i_valid <= 1'b0;
            end else if (samples_to_send.size() != 0) begin
                s = samples_to_send.pop_front();
                i_valid    <= 1'b1;
                i_position <= s.position;
                i_closing  <= s.closing;
                if (tx_calm != 0) begin
                    tx_calm <= tx_calm - 1;
                    tx_gap  <= 0;
                end else begin
                    tx_gap <= pick_gap();
                    if ($urandom_range(0, 49) == 0) tx_calm <= $urandom_range(20, 120);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    int unsigned rx_stall = 0;
    int unsigned rx_calm  = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_stall != 0) begin
            rx_stall <= rx_stall - 1;
            i_ready  <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (rx_calm != 0) begin
                rx_calm <= rx_calm - 1;
            end else if ($urandom_range(0, 3) == 0) begin
                rx_stall <= pick_gap();
                if ($urandom_range(0, 39) == 0) rx_calm <= $urandom_range(50, 300);
            end
        end
    end

    always @(posedge i_clk) begin : fault_monitor
        t_fault  want;
        t_sample s;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_faults.size() == 0) begin
                    $display("%0t: unexpected beat, steep_fault %0b jam_fault %0b",
                             $time, o_steep_fault, o_jam_fault);
                    errors++;
                end else begin
                    want = pending_faults.pop_front();
                    if (o_steep_fault !== want.steep) begin
                        $display("%0t: steep_fault expected %0b got %0b",
                                 $time, want.steep, o_steep_fault);
                        errors++;
                    end
                    if (o_jam_fault !== want.jam) begin
                        $display("%0t: jam_fault expected %0b got %0b",
                                 $time, want.jam, o_jam_fault);
                        errors++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                s.position = i_position;
                s.closing  = i_closing;
                pending_faults.push_back(judge_sample(s));
            end
        end
    end

    int unsigned stuck = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
            if (stuck >= STUCK_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic [clsf_pkg::APB_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr[3:2])
            clsf_pkg::REG_SLOPE_THR:   slope_thr_m  = data[clsf_pkg::THR_W-1:0];
            clsf_pkg::REG_CHANGE_THR:  change_thr_m = data[clsf_pkg::THR_W-1:0];
            clsf_pkg::REG_MIN_CLOSING: min_close_m  = data[clsf_pkg::MIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_sample(input int pos, input logic cl, inout int count);
        t_sample s;
        s.position = clsf_pkg::POS_W'(pos);
        s.closing  = cl;
        samples_to_send.push_back(s);
        count++;
    endtask

    // A closing stroke: a few fully open beats, then a falling position with
    // jitter, sudden drops, small rebounds and the odd reading above open.
    task automatic add_closing_stroke(inout int count);
        int pos, step, n;
        repeat ($urandom_range(0, 15))
            push_sample(clsf_pkg::FULL_OPEN, $urandom_range(0, 3) != 0, count);
        pos  = clsf_pkg::FULL_OPEN;
        step = $urandom_range(0, 1200);
        n    = $urandom_range(3, 90);
        repeat (n) begin
            if ($urandom_range(0, 14) == 0) pos -= $urandom_range(0, 8000);
            else pos -= step + $urandom_range(0, 60);
            if ($urandom_range(0, 24) == 0) pos += $urandom_range(0, 3000);
            if (pos < 0) pos = 0;
            if (pos > clsf_pkg::FULL_OPEN) pos = clsf_pkg::FULL_OPEN;
            if ($urandom_range(0, 39) == 0)
                push_sample($urandom_range(clsf_pkg::FULL_OPEN + 1, 65535), 1'b1, count);
            else
                push_sample(pos, $urandom_range(0, 19) != 0, count);
        end
    endtask

    task automatic add_opening_stroke(inout int count);
        int pos, step;
        pos  = $urandom_range(0, 20000);
        step = $urandom_range(100, 2000);
        while (pos < clsf_pkg::FULL_OPEN) begin
            push_sample(pos, $urandom_range(0, 1), count);
            pos += step + $urandom_range(0, 50);
        end
        push_sample(clsf_pkg::FULL_OPEN, $urandom_range(0, 1), count);
    endtask

    task automatic load_random(input int target);
        int count;
        int unsigned r;
        count = 0;
        @(negedge i_clk);
        while (count < target) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                add_closing_stroke(count);
            end else if (r == 7) begin
                repeat ($urandom_range(1, 10))
                    push_sample($urandom_range(0, 65535), $urandom_range(0, 1), count);
            end else if (r == 8) begin
                repeat ($urandom_range(20, 120))
                    push_sample(clsf_pkg::FULL_OPEN, $urandom_range(0, 1), count);
            end else begin
                add_opening_stroke(count);
            end
        end
    endtask

    task automatic load_directed();
        int count;
        count = 0;
        @(negedge i_clk);
        push_sample(clsf_pkg::FULL_OPEN, 1'b1, count);     // every stored sample open
        push_sample(0, 1'b1, count);
        push_sample(65535, 1'b1, count);                   // far above fully open
        push_sample(clsf_pkg::FULL_OPEN + 1, 1'b0, count); // not closing
        push_sample(clsf_pkg::FULL_OPEN, 1'b1, count);
        for (int k = 1; k <= 13; k++)
            push_sample(clsf_pkg::FULL_OPEN - 1000 * k, 1'b1, count);
        push_sample(20000, 1'b1, count);                   // sudden jump
        push_sample(clsf_pkg::FULL_OPEN, 1'b1, count);
        push_sample(0, 1'b0, count);
        push_sample(40000, 1'b1, count);
    endtask

    // Checked on the falling edge so that the driver's pop and its valid agree.
    task automatic drain();
        @(negedge i_clk);
        while (samples_to_send.size() != 0 || i_valid || pending_faults.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic configure(input int ph);
        case (ph)
            0: begin
                reg_write({clsf_pkg::REG_SLOPE_THR, 2'b00}, 32'd0);
                reg_write({clsf_pkg::REG_CHANGE_THR, 2'b00}, 32'd0);
                reg_write({clsf_pkg::REG_MIN_CLOSING, 2'b00}, 32'd0);
            end
            1: begin
                reg_write({clsf_pkg::REG_SLOPE_THR, 2'b00}, 32'd3276800);
                reg_write({clsf_pkg::REG_CHANGE_THR, 2'b00}, 32'd3276800);
                reg_write({clsf_pkg::REG_MIN_CLOSING, 2'b00}, 32'd1024);
            end
            2: begin
                // Upper bits must be dropped by the register width.
                reg_write({clsf_pkg::REG_SLOPE_THR, 2'b00}, 32'hFFFF_FFFF);
                reg_write({clsf_pkg::REG_CHANGE_THR, 2'b00}, 32'hFFFF_FFFF);
                reg_write({clsf_pkg::REG_MIN_CLOSING, 2'b00}, 32'hFFFF_FFFF);
            end
            default: begin
                reg_write({clsf_pkg::REG_SLOPE_THR, 2'b00}, $urandom_range(20000, 90000));
                reg_write({clsf_pkg::REG_CHANGE_THR, 2'b00}, $urandom_range(0, 20000));
                reg_write({clsf_pkg::REG_MIN_CLOSING, 2'b00}, $urandom_range(0, 101));
            end
        endcase
        reg_write(ADDR_SPARE, $urandom());
    endtask

    initial begin
        clear_history();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        load_directed();
        drain();
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            configure(ph);
            load_random(PHASE_ITEMS);
            drain();
        end
        repeat (END_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_faults.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### closing_slope_fault_detector.f
rtl/clsf_pkg.sv
rtl/clsf_regs.sv
rtl/clsf_ctrl.sv
rtl/clsf_dp.sv
rtl/closing_slope_fault_detector.sv
rtl/clsf_checker.sv
tb/closing_slope_fault_detector_tb.sv
